@@ rtl/quaternion_to_euler_unit_defines.svh @@
// Assertion macros for the quaternion to Euler angle unit.
// Used by the top level only; depends on nothing else.
`ifndef QUATERNION_TO_EULER_UNIT_DEFINES_SVH
`define QUATERNION_TO_EULER_UNIT_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define Q2E_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define Q2E_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/q2e_pkg.sv @@
// Shared constants, types and CORDIC angle table for the quaternion to Euler unit.
// Depends on nothing.
package q2e_pkg;
	localparam int CordicSteps = 16;
	localparam int AngTableLen = 24;
	// Operands: products up to 2^33 in magnitude, scaled by 2^16, plus CORDIC growth.
	localparam int CW = 53;
	localparam int SQ_BITS = 31;
	localparam int PIPE = CordicSteps + 2 * SQ_BITS + 6;

	typedef logic signed [CW-1:0] cval_t;

	function automatic logic [31:0] elem_angle(input int i);
		logic [31:0] t [AngTableLen];
		t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
			32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
			32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
			32'd166886, 32'd83443, 32'd41722, 32'd20861,
			32'd10430, 32'd5215, 32'd2608, 32'd1304,
			32'd652, 32'd326, 32'd163, 32'd81};
		if (i < AngTableLen) return t[i];
		return 32'd0;
	endfunction
endpackage

@@ rtl/q2e_cordic_pipe.sv @@
// Pipelined CORDIC vectoring atan2, one iteration per stage.
// Depends on q2e_pkg. Output is a 16-bit binary angle with pi = 32768.
module q2e_cordic_pipe (
	input  logic                 clk,
	input  q2e_pkg::cval_t       in_x,
	input  q2e_pkg::cval_t       in_y,
	output logic [15:0]          angle
);
	import q2e_pkg::*;

	cval_t       x_s [CordicSteps+1];
	cval_t       y_s [CordicSteps+1];
	logic [31:0] acc_s [CordicSteps+1];
	logic        zero_s [CordicSteps+1];

	// Stage 0 folds the left half-plane onto the right and marks a zero vector.
	always_ff @(posedge clk) begin
		if (in_x < 0) begin
			x_s[0] <= -in_x;
			y_s[0] <= -in_y;
			acc_s[0] <= 32'h8000_0000;
		end else begin
			x_s[0] <= in_x;
			y_s[0] <= in_y;
			acc_s[0] <= 32'd0;
		end
		zero_s[0] <= (in_x == 0) && (in_y == 0);
	end

	for (genvar i = 0; i < CordicSteps; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (y_s[i] > 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				acc_s[i+1] <= acc_s[i] + elem_angle(i);
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				acc_s[i+1] <= acc_s[i] - elem_angle(i);
			end
			zero_s[i+1] <= zero_s[i];
		end
	end

	logic [31:0] rounded;
	assign rounded = acc_s[CordicSteps] + 32'h0000_8000;
	assign angle = zero_s[CordicSteps] ? 16'd0 : rounded[31:16];
endmodule

@@ rtl/quaternion_to_euler_unit.sv @@
// Pipeline: a register stage each for the products, the sums and the radicand,
// 31 square root stages, one fold stage, 16 CORDIC iterations and the output
// register; done rises with the results. Throughput: one quaternion per cycle;
// busy stays low and results cannot be held off.
// Reset clears the valid bits of the pipeline; the datapath itself is not reset.
// Depends on q2e_pkg, q2e_cordic_pipe and the assertion macro header.
`include "quaternion_to_euler_unit_defines.svh"
module quaternion_to_euler_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic               done,
	output logic signed [15:0] roll_angle,
	output logic signed [15:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic               pitch_clamped
);
	import q2e_pkg::*;

	localparam int RootStages = SQ_BITS;
	localparam int DelayLen = RootStages + 1;
	localparam int TotalLat = DelayLen + CordicSteps + 4;

	logic accept;
	assign busy = 1'b0;
	assign accept = start && !busy;

	// Stage 1: the nine products, each exact in Q2.30.
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;
	always_ff @(posedge clk) begin
		wx_s1 <= quat_w * quat_x;
		yz_s1 <= quat_y * quat_z;
		xx_s1 <= quat_x * quat_x;
		yy_s1 <= quat_y * quat_y;
		wz_s1 <= quat_w * quat_z;
		xy_s1 <= quat_x * quat_y;
		zz_s1 <= quat_z * quat_z;
		wy_s1 <= quat_w * quat_y;
		zx_s1 <= quat_z * quat_x;
	end

	// Stage 2: the five operands in the 2^30 scale.
	localparam logic signed [34:0] OneQ30 = 35'sd1 <<< 30;
	logic signed [34:0] sinr_s2, cosr_s2, siny_s2, cosy_s2, sinp_s2;
	always_ff @(posedge clk) begin
		sinr_s2 <= 35'(2 * (35'(wx_s1) + 35'(yz_s1)));
		cosr_s2 <= OneQ30 - 35'(2 * (35'(xx_s1) + 35'(yy_s1)));
		siny_s2 <= 35'(2 * (35'(wz_s1) + 35'(xy_s1)));
		cosy_s2 <= OneQ30 - 35'(2 * (35'(yy_s1) + 35'(zz_s1)));
		sinp_s2 <= 35'(2 * (35'(wy_s1) - 35'(zx_s1)));
	end

	// Pitch: when |s| < 1, 2^60 - s*s is registered from a 31x31 product of |s|,
	// then the square root is taken one result bit a stage.
	logic        clamp_s2;
	logic [30:0] sabs_s2;
	assign clamp_s2 = (sinp_s2 >= OneQ30) || (sinp_s2 <= -OneQ30);
	assign sabs_s2 = sinp_s2[34] ? 31'(-sinp_s2) : 31'(sinp_s2);

	logic [61:0] rad_s3;
	always_ff @(posedge clk) begin
		rad_s3 <= clamp_s2 ? 62'd0 : (62'd1 << 60) - 62'(sabs_s2 * sabs_s2);
	end

	// Restoring square root: stage k decides result bit 30-k.
	logic [61:0] rem_r [RootStages+1];
	logic [30:0] root_r [RootStages+1];
	assign rem_r[0] = rad_s3;
	assign root_r[0] = '0;
	logic [61:0] rem_q [RootStages];
	logic [30:0] root_q [RootStages];
	for (genvar k = 0; k < RootStages; k++) begin : g_root
		localparam int B = RootStages - 1 - k;
		logic [30:0] trial;
		logic [61:0] trial_sq;
		assign trial = root_r[k] | (31'd1 << B);
		// Compare trial^2 with the radicand via incremental remainder.
		assign trial_sq = (62'({root_r[k], 1'b0}) << B) + (62'd1 << (2 * B));
		always_ff @(posedge clk) begin
			if (rem_r[k] >= trial_sq) begin
				rem_q[k] <= rem_r[k] - trial_sq;
				root_q[k] <= trial;
			end else begin
				rem_q[k] <= rem_r[k];
				root_q[k] <= root_r[k];
			end
		end
		assign rem_r[k+1] = rem_q[k];
		assign root_r[k+1] = root_q[k];
	end

	// Delay lines carry the other operands past the product and root stages.
	logic signed [34:0] sinr_d [DelayLen], cosr_d [DelayLen], siny_d [DelayLen];
	logic signed [34:0] cosy_d [DelayLen], sinp_d [DelayLen];
	logic               clamp_d [DelayLen];
	always_ff @(posedge clk) begin
		sinr_d[0] <= sinr_s2; cosr_d[0] <= cosr_s2; siny_d[0] <= siny_s2;
		cosy_d[0] <= cosy_s2; sinp_d[0] <= sinp_s2; clamp_d[0] <= clamp_s2;
		for (int j = 1; j < DelayLen; j++) begin
			sinr_d[j] <= sinr_d[j-1]; cosr_d[j] <= cosr_d[j-1];
			siny_d[j] <= siny_d[j-1]; cosy_d[j] <= cosy_d[j-1];
			sinp_d[j] <= sinp_d[j-1]; clamp_d[j] <= clamp_d[j-1];
		end
	end
	// Tap where the root for the same item is ready.
	localparam int Tap = RootStages;

	function automatic cval_t scale(input logic signed [34:0] v);
		return cval_t'(v) <<< 16;
	endfunction

	logic [15:0] roll_raw, yaw_raw, pitch_raw;
	q2e_cordic_pipe u_roll (.clk,
		.in_x(scale(cosr_d[Tap])), .in_y(scale(sinr_d[Tap])), .angle(roll_raw));
	q2e_cordic_pipe u_yaw (.clk,
		.in_x(scale(cosy_d[Tap])), .in_y(scale(siny_d[Tap])), .angle(yaw_raw));
	q2e_cordic_pipe u_pitch (.clk,
		.in_x(scale(35'(root_r[RootStages]))), .in_y(scale(sinp_d[Tap])),
		.angle(pitch_raw));

	logic clamp_c [CordicSteps+1];
	logic sneg_c [CordicSteps+1];
	always_ff @(posedge clk) begin
		clamp_c[0] <= clamp_d[Tap];
		sneg_c[0] <= !(sinp_d[Tap] > 0);
		for (int j = 1; j <= CordicSteps; j++) begin
			clamp_c[j] <= clamp_c[j-1];
			sneg_c[j] <= sneg_c[j-1];
		end
	end

	logic signed [15:0] pitch_lim;
	always_comb begin
		if (clamp_c[CordicSteps]) begin
			pitch_lim = sneg_c[CordicSteps] ? -16'sd16384 : 16'sd16384;
		end else if ($signed(pitch_raw) > 16'sd16384) begin
			pitch_lim = 16'sd16384;
		end else if ($signed(pitch_raw) < -16'sd16384) begin
			pitch_lim = -16'sd16384;
		end else begin
			pitch_lim = $signed(pitch_raw);
		end
	end

	always_ff @(posedge clk) begin
		roll_angle <= $signed(roll_raw);
		yaw_angle <= $signed(yaw_raw);
		pitch_angle <= pitch_lim;
		pitch_clamped <= clamp_c[CordicSteps];
	end

	// Valid bits travel alongside the datapath.
	logic [TotalLat-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[TotalLat-2:0], accept};
		end
	end
	assign done = vld_q[TotalLat-1];

	`Q2E_ASSERT_IMPL(a_never_busy, 1'b1, !busy, "busy raised")
	`Q2E_ASSERT_IMPL(a_clamp_pitch, done && pitch_clamped,
		pitch_angle == 16'sd16384 || pitch_angle == -16'sd16384, "clamped pitch off limit")
	`Q2E_ASSERT_IMPL(a_pitch_range, done,
		pitch_angle <= 16'sd16384 && pitch_angle >= -16'sd16384, "pitch out of range")
endmodule
